// ===== hdl/tjs_pkg.sv =====
// Shared types, constants and helper functions for the two-link joint solver.
// No dependencies; used by every module of the block.
package tjs_pkg;

  localparam int POS_W   = 24;
  localparam int ANG_W   = 18;
  localparam int CFG_W   = 11;
  localparam int CFGI_W  = 3;
  localparam int SQ_W    = 60;
  localparam int RT_W    = 30;
  localparam int CX_W    = 34;
  localparam int ACC_W   = 26;
  localparam int TAB_W   = 22;
  localparam int TABLE_LEN = 24;
  localparam int NRM_W   = 40;

  localparam logic [CFGI_W-1:0] CFG_UPPER = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_LOWER = 3'd1;
  localparam logic [CFGI_W-1:0] CFG_RMIN  = 3'd2;
  localparam logic [CFGI_W-1:0] CFG_RMAX  = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_SCALE = 3'd4;
  localparam logic [CFGI_W-1:0] CFG_GAIN  = 3'd5;

  localparam logic [9:0]  RST_UPPER = 10'd215;
  localparam logic [9:0]  RST_LOWER = 10'd160;
  localparam logic [10:0] RST_RMIN  = 11'd100;
  localparam logic [10:0] RST_RMAX  = 11'd350;
  localparam logic [5:0]  RST_SCALE = 6'd10;
  localparam logic [3:0]  RST_GAIN  = 4'd3;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_MINUS = 2'd1;
  localparam logic [1:0] DIR_PLUS  = 2'd2;

  // horizontal distance clamp, Q.8
  localparam logic [23:0] HORIZ_MIN = 24'd2560;
  localparam logic [23:0] HORIZ_MAX = 24'd256000;
  // 90 and 270 degrees in Q.16
  localparam logic signed [ACC_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [27:0]      DEG270 = 28'sd17694720;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_GAIN, OP_SQX, OP_SQZ, OP_SQY, OP_SUM, OP_CMUL,
    OP_CCLAMP, OP_HCLAMP, OP_BB, OP_CC, OP_BC, OP_AB, OP_ABW, OP_ACLOAD,
    OP_NORM, OP_MD, OP_MM, OP_ACSQ, OP_ACCOR, OP_ACSTORE, OP_EL, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic gamma;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic cordic_done;
    logic norm_done;
  } stat_t;

  // atan(2^-i) in degrees Q.16, rounded
  function automatic logic [TAB_W-1:0] atan_q16(input logic [4:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic [POS_W-1:0] sat24(input logic signed [63:0] v);
    logic [POS_W-1:0] r;
    if (v > 64'sd8388607) r = 24'h7FFFFF;
    else if (v < -64'sd8388608) r = 24'h800000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

// ===== hdl/two_link_arm_joint_solver_core.sv =====
// Top level of the two-link arm joint solver: sequencer plus datapath.
// Depends on tjs_pkg, tjs_ctrl and tjs_dp.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | pos x/y/z, move/select/start, trigger
//  out     | out_valid / out_stall| joint angles, rel x/y/z, enable, trig, dir
//  cfg     | cfg_we               | cfg_index, cfg_wdata (write only)
//
// One word at a time. The work per word is the root runs, the CORDIC waits, the
// normalize shifts and the sequencing, set mostly by the shared bit-serial square
// root; it is shorter when a CORDIC input is the zero vector.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// enable toggle, the move edge history and the centre.
// A finished word sits in the output register; the next input word is taken
// meanwhile and, if still stalled at the end of that word, the core waits.
module two_link_arm_joint_solver_core #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tjs_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [tjs_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [tjs_pkg::POS_W-1:0]    in_pos_z,
  input  logic                                in_move_pressed,
  input  logic                                in_select_pressed,
  input  logic                                in_start_pressed,
  input  logic [7:0]                          in_trigger_level,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tjs_pkg::ANG_W-1:0]    out_joint_one_angle,
  output logic signed [tjs_pkg::ANG_W-1:0]    out_joint_two_angle,
  output logic signed [tjs_pkg::POS_W-1:0]    out_rel_x,
  output logic signed [tjs_pkg::POS_W-1:0]    out_rel_y,
  output logic signed [tjs_pkg::POS_W-1:0]    out_rel_z,
  output logic                                out_arm_enabled,
  output logic [7:0]                          out_trigger_out,
  output logic [1:0]                          out_direction_command,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [tjs_pkg::CFGI_W-1:0]          cfg_index,
  input  logic [tjs_pkg::CFG_W-1:0]           cfg_wdata
);

  // command from the sequencer, status back from the datapath
  tjs_pkg::cmd_t  cmd;
  tjs_pkg::stat_t stat;

  tjs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tjs_dp #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_pos_x              (in_pos_x),
    .in_pos_y              (in_pos_y),
    .in_pos_z              (in_pos_z),
    .in_move_pressed       (in_move_pressed),
    .in_select_pressed     (in_select_pressed),
    .in_start_pressed      (in_start_pressed),
    .in_trigger_level      (in_trigger_level),
    .out_joint_one_angle   (out_joint_one_angle),
    .out_joint_two_angle   (out_joint_two_angle),
    .out_rel_x             (out_rel_x),
    .out_rel_y             (out_rel_y),
    .out_rel_z             (out_rel_z),
    .out_arm_enabled       (out_arm_enabled),
    .out_trigger_out       (out_trigger_out),
    .out_direction_command (out_direction_command)
  );

endmodule

// ===== hdl/tjs_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on tjs_pkg for widths.
module tjs_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tjs_pkg::SQ_W-1:0]   radicand,
  output logic [tjs_pkg::RT_W-1:0]   root,
  output logic                       done
);

  logic [tjs_pkg::SQ_W-1:0] v_r, r_r, bit_r;
  logic                     busy_r, done_r;
  logic [tjs_pkg::SQ_W:0]   trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};
  assign root  = r_r[tjs_pkg::RT_W-1:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= radicand;
        r_r    <= '0;
        bit_r  <= {2'b01, {(tjs_pkg::SQ_W-2){1'b0}}};
      end else if (busy_r) begin
        if ({1'b0, v_r} >= trial) begin
          v_r <= v_r - trial[tjs_pkg::SQ_W-1:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/tjs_cordic.sv =====
// Vectoring CORDIC atan2 in degrees Q.16, one rotation per cycle.
// Depends on tjs_pkg for widths and the arctangent table.
module tjs_cordic #(
  parameter int ITER = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [tjs_pkg::CX_W-1:0]     y_in,
  input  logic signed [tjs_pkg::CX_W-1:0]     x_in,
  output logic signed [tjs_pkg::ACC_W-1:0]    angle,
  output logic                                done
);

  localparam int CNT_W = $clog2(ITER + 1);

  logic signed [tjs_pkg::CX_W-1:0]  x_r, y_r, dx, dy;
  logic signed [tjs_pkg::ACC_W-1:0] acc_r, step;
  logic [CNT_W-1:0]                 i_r;
  logic                             busy_r, done_r;

  assign dx    = y_r >>> i_r;
  assign dy    = x_r >>> i_r;
  assign step  = $signed(tjs_pkg::ACC_W'(tjs_pkg::atan_q16(5'(i_r))));
  assign angle = acc_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          acc_r  <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x_in < 0) begin
            // quarter turn toward +x first
            if (y_in >= 0) begin
              x_r <= y_in; y_r <= -x_in; acc_r <= tjs_pkg::DEG90;
            end else begin
              x_r <= -y_in; y_r <= x_in; acc_r <= -tjs_pkg::DEG90;
            end
          end else begin
            x_r <= x_in; y_r <= y_in; acc_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r >= 0) begin
          x_r <= x_r + dx; y_r <= y_r - dy; acc_r <= acc_r + step;
        end else begin
          x_r <= x_r - dx; y_r <= y_r + dy; acc_r <= acc_r - step;
        end
        i_r <= i_r + 1'b1;
        if (i_r == CNT_W'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/tjs_ctrl.sv =====
// Sequencer for the joint solver: walks the datapath through one word.
// Depends on tjs_pkg for command and status types.
module tjs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tjs_pkg::stat_t stat,
  output tjs_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_GAIN, S_SQX, S_SQZ, S_SQY, S_SUM, S_RW1, S_CMUL, S_CCLAMP,
    S_RW2, S_HCLAMP, S_BB, S_CC, S_BC, S_AB, S_ABW, S_AC_LOAD, S_AC_NORM,
    S_AC_MD, S_AC_MM, S_AC_SQ, S_AC_SQW, S_AC_COR, S_AC_CORW, S_EL, S_ELW,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   gamma_r, gamma_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    gamma_nxt     = gamma_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = tjs_pkg::OP_NONE;
    cmd.gamma     = gamma_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = tjs_pkg::OP_LOAD;
        gamma_nxt = 1'b0;
        state_nxt = S_GAIN;
      end
      S_GAIN:   begin cmd.op = tjs_pkg::OP_GAIN;   state_nxt = S_SQX;    end
      S_SQX:    begin cmd.op = tjs_pkg::OP_SQX;    state_nxt = S_SQZ;    end
      S_SQZ:    begin cmd.op = tjs_pkg::OP_SQZ;    state_nxt = S_SQY;    end
      S_SQY:    begin cmd.op = tjs_pkg::OP_SQY;    state_nxt = S_SUM;    end
      S_SUM:    begin cmd.op = tjs_pkg::OP_SUM;    state_nxt = S_RW1;    end
      S_RW1:    if (stat.sqrt_done) state_nxt = S_CMUL;
      S_CMUL:   begin cmd.op = tjs_pkg::OP_CMUL;   state_nxt = S_CCLAMP; end
      S_CCLAMP: begin cmd.op = tjs_pkg::OP_CCLAMP; state_nxt = S_RW2;    end
      S_RW2:    if (stat.sqrt_done) state_nxt = S_HCLAMP;
      S_HCLAMP: begin cmd.op = tjs_pkg::OP_HCLAMP; state_nxt = S_BB;     end
      S_BB:     begin cmd.op = tjs_pkg::OP_BB;     state_nxt = S_CC;     end
      S_CC:     begin cmd.op = tjs_pkg::OP_CC;     state_nxt = S_BC;     end
      S_BC:     begin cmd.op = tjs_pkg::OP_BC;     state_nxt = S_AB;     end
      S_AB:     begin cmd.op = tjs_pkg::OP_AB;     state_nxt = S_ABW;    end
      S_ABW:    begin cmd.op = tjs_pkg::OP_ABW;    state_nxt = S_AC_LOAD; end
      S_AC_LOAD: begin cmd.op = tjs_pkg::OP_ACLOAD; state_nxt = S_AC_NORM; end
      S_AC_NORM: begin
        if (stat.norm_done) state_nxt = S_AC_MD;
        else cmd.op = tjs_pkg::OP_NORM;
      end
      S_AC_MD:  begin cmd.op = tjs_pkg::OP_MD;     state_nxt = S_AC_MM;  end
      S_AC_MM:  begin cmd.op = tjs_pkg::OP_MM;     state_nxt = S_AC_SQ;  end
      S_AC_SQ:  begin cmd.op = tjs_pkg::OP_ACSQ;   state_nxt = S_AC_SQW; end
      S_AC_SQW: if (stat.sqrt_done) state_nxt = S_AC_COR;
      S_AC_COR: begin cmd.op = tjs_pkg::OP_ACCOR;  state_nxt = S_AC_CORW; end
      S_AC_CORW: if (stat.cordic_done) begin
        cmd.op = tjs_pkg::OP_ACSTORE;
        if (gamma_r) state_nxt = S_EL;
        else begin
          gamma_nxt = 1'b1;
          state_nxt = S_AC_LOAD;
        end
      end
      S_EL:     begin cmd.op = tjs_pkg::OP_EL;     state_nxt = S_ELW;    end
      S_ELW:    if (stat.cordic_done) state_nxt = S_DONE;
      S_DONE: if (!(out_valid_r && out_stall)) begin
        cmd.op        = tjs_pkg::OP_OUT;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gamma_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gamma_r     <= gamma_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/tjs_dp.sv =====
// Datapath of the joint solver: registers, shared multiplier, root and CORDIC.
// Depends on tjs_pkg, tjs_sqrt and tjs_cordic.
module tjs_dp #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tjs_pkg::cmd_t                       cmd,
  output tjs_pkg::stat_t                      stat,
  input  logic                                cfg_we,
  input  logic [tjs_pkg::CFGI_W-1:0]          cfg_index,
  input  logic [tjs_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic signed [tjs_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [tjs_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [tjs_pkg::POS_W-1:0]    in_pos_z,
  input  logic                                in_move_pressed,
  input  logic                                in_select_pressed,
  input  logic                                in_start_pressed,
  input  logic [7:0]                          in_trigger_level,
  output logic signed [tjs_pkg::ANG_W-1:0]    out_joint_one_angle,
  output logic signed [tjs_pkg::ANG_W-1:0]    out_joint_two_angle,
  output logic signed [tjs_pkg::POS_W-1:0]    out_rel_x,
  output logic signed [tjs_pkg::POS_W-1:0]    out_rel_y,
  output logic signed [tjs_pkg::POS_W-1:0]    out_rel_z,
  output logic                                out_arm_enabled,
  output logic [7:0]                          out_trigger_out,
  output logic [1:0]                          out_direction_command
);

  // configuration
  logic [9:0]  upper_r, lower_r;
  logic [10:0] rmin_r, rmax_r;
  logic [5:0]  scale_r;
  logic [3:0]  gain_r;

  // tracking state
  logic                            enable_r, last_move_r;
  logic signed [tjs_pkg::POS_W-1:0] cx_r, cy_r, cz_r;

  // work registers
  logic [tjs_pkg::POS_W-1:0] rx_r, ry_r, rz_r;
  logic signed [24:0]        dy_r;
  logic [7:0]                trig_r;
  logic [1:0]                dir_r;
  logic [47:0]               h2_r;
  logic [18:0]               c_r;
  logic [17:0]               h_r;
  logic [19:0]               aa_r, bb_r, ab_r;
  logic [37:0]               cc_r;
  logic [28:0]               bc_r;
  logic [tjs_pkg::NRM_W-1:0] du_r, mu_r;
  logic                      neg_r;
  logic [tjs_pkg::SQ_W-1:0]  t_r;
  logic signed [tjs_pkg::ACC_W-1:0] alpha_r, gamma_r;
  logic signed [63:0]        prod_r;

  // multiplier
  logic signed [31:0] ma, mb;
  logic signed [63:0] pw;
  assign pw = ma * mb;

  // sqrt / cordic hookup
  logic                             sq_start, sq_done;
  logic [tjs_pkg::SQ_W-1:0]         sq_in;
  logic [tjs_pkg::RT_W-1:0]         sq_root;
  logic                             co_start, co_done;
  logic signed [tjs_pkg::CX_W-1:0]  co_y, co_x, mu_s;
  logic signed [tjs_pkg::ACC_W-1:0] co_ang;

  // input side
  logic                      edge_mv;
  logic signed [24:0]        dx, dyv, dz;
  logic signed [tjs_pkg::POS_W-1:0] ncx, ncy, ncz;

  assign edge_mv = in_move_pressed && !last_move_r;
  assign ncx = edge_mv ? in_pos_x : cx_r;
  assign ncy = edge_mv ? in_pos_y : cy_r;
  assign ncz = edge_mv ? in_pos_z : cz_r;
  assign dx  = 25'(in_pos_x) - 25'(ncx);
  assign dyv = 25'(in_pos_y) - 25'(ncy);
  assign dz  = 25'(ncz) - 25'(in_pos_z);

  // clamps
  logic [18:0] lo, hi, c_cl;
  logic [29:0] cval;
  logic [23:0] hroot;
  logic [17:0] h_cl;
  assign lo   = {rmin_r, 8'b0};
  assign hi   = {rmax_r, 8'b0};
  assign cval = prod_r[29:0];
  always_comb begin
    if (!(30'(lo) <= cval && cval <= 30'(hi))) c_cl = (cval < 30'(lo)) ? lo : hi;
    else c_cl = cval[18:0];
  end
  assign hroot = sq_root[23:0];
  always_comb begin
    if (hroot < tjs_pkg::HORIZ_MIN) h_cl = tjs_pkg::HORIZ_MIN[17:0];
    else if (hroot > tjs_pkg::HORIZ_MAX) h_cl = tjs_pkg::HORIZ_MAX[17:0];
    else h_cl = hroot[17:0];
  end

  // law-of-cosines numerator and denominator
  logic signed [40:0]        n_al, n_ga, n_sel, n_mag;
  logic [tjs_pkg::NRM_W-1:0] d_sel, m_sel;
  assign n_al  = ((41'(bb_r) - 41'(aa_r)) <<< 16) + 41'(cc_r);
  assign n_ga  = ((41'(aa_r) + 41'(bb_r)) <<< 16) - 41'(cc_r);
  assign n_sel = cmd.gamma ? n_ga : n_al;
  assign d_sel = cmd.gamma ? (40'(ab_r) << 17) : (40'(bc_r) << 9);
  assign n_mag = n_sel[40] ? -n_sel : n_sel;
  assign m_sel = (n_mag[39:0] > d_sel) ? d_sel : n_mag[39:0];

  assign stat.norm_done   = (du_r[tjs_pkg::NRM_W-1:tjs_pkg::RT_W] == '0);
  assign stat.sqrt_done   = sq_done;
  assign stat.cordic_done = co_done;

  assign mu_s = $signed(tjs_pkg::CX_W'(mu_r[tjs_pkg::RT_W-1:0]));

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      tjs_pkg::OP_GAIN:   begin ma = 32'(dy_r);           mb = 32'(gain_r);  end
      tjs_pkg::OP_SQX:    begin ma = 32'($signed(rx_r));  mb = 32'($signed(rx_r)); end
      tjs_pkg::OP_SQZ:    begin ma = 32'($signed(rz_r));  mb = 32'($signed(rz_r)); end
      tjs_pkg::OP_SQY:    begin ma = 32'($signed(ry_r));  mb = 32'($signed(ry_r)); end
      tjs_pkg::OP_CMUL:   begin ma = 32'(sq_root[23:0]);  mb = 32'(scale_r); end
      tjs_pkg::OP_HCLAMP: begin ma = 32'(upper_r);        mb = 32'(upper_r); end
      tjs_pkg::OP_BB:     begin ma = 32'(lower_r);        mb = 32'(lower_r); end
      tjs_pkg::OP_CC:     begin ma = 32'(c_r);            mb = 32'(c_r);     end
      tjs_pkg::OP_BC:     begin ma = 32'(lower_r);        mb = 32'(c_r);     end
      tjs_pkg::OP_AB:     begin ma = 32'(upper_r);        mb = 32'(lower_r); end
      tjs_pkg::OP_MD:     begin ma = 32'(du_r[29:0]);     mb = 32'(du_r[29:0]); end
      tjs_pkg::OP_MM:     begin ma = 32'(mu_r[29:0]);     mb = 32'(mu_r[29:0]); end
      default: ;
    endcase
  end

  always_comb begin
    sq_start = 1'b0;
    sq_in    = '0;
    co_start = 1'b0;
    co_y     = '0;
    co_x     = '0;
    case (cmd.op)
      tjs_pkg::OP_SUM: begin
        sq_start = 1'b1;
        sq_in    = 60'(h2_r + prod_r[47:0]);
      end
      tjs_pkg::OP_CCLAMP: begin
        sq_start = 1'b1;
        sq_in    = 60'(h2_r);
      end
      tjs_pkg::OP_ACSQ: begin
        sq_start = 1'b1;
        sq_in    = t_r - prod_r[59:0];
      end
      tjs_pkg::OP_ACCOR: begin
        co_start = 1'b1;
        co_y     = $signed(tjs_pkg::CX_W'(sq_root));
        co_x     = neg_r ? -mu_s : mu_s;
      end
      tjs_pkg::OP_EL: begin
        co_start = 1'b1;
        co_y     = $signed(tjs_pkg::CX_W'(h_r));
        co_x     = tjs_pkg::CX_W'($signed(ry_r));
      end
      default: ;
    endcase
  end

  // joint angles, Q.16 then rounded to Q.8
  logic signed [27:0] j1, j2, j1r, j2r;
  assign j1  = tjs_pkg::DEG270 - 28'(alpha_r) - 28'(co_ang);
  assign j2  = j1 - 28'(gamma_r);
  assign j1r = (j1 + 28'sd128) >>> 8;
  assign j2r = (j2 + 28'sd128) >>> 8;

  // control-side state: config, enable and centre
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r     <= tjs_pkg::RST_UPPER;
      lower_r     <= tjs_pkg::RST_LOWER;
      rmin_r      <= tjs_pkg::RST_RMIN;
      rmax_r      <= tjs_pkg::RST_RMAX;
      scale_r     <= tjs_pkg::RST_SCALE;
      gain_r      <= tjs_pkg::RST_GAIN;
      enable_r    <= 1'b0;
      last_move_r <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tjs_pkg::CFG_UPPER: upper_r <= cfg_wdata[9:0];
          tjs_pkg::CFG_LOWER: lower_r <= cfg_wdata[9:0];
          tjs_pkg::CFG_RMIN:  rmin_r  <= cfg_wdata;
          tjs_pkg::CFG_RMAX:  rmax_r  <= cfg_wdata;
          tjs_pkg::CFG_SCALE: scale_r <= cfg_wdata[5:0];
          tjs_pkg::CFG_GAIN:  gain_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (cmd.op == tjs_pkg::OP_LOAD) begin
        last_move_r <= in_move_pressed;
        if (edge_mv) begin
          enable_r <= !enable_r;
          cx_r     <= in_pos_x;
          cy_r     <= in_pos_y;
          cz_r     <= in_pos_z;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= pw;
    case (cmd.op)
      tjs_pkg::OP_LOAD: begin
        rx_r   <= tjs_pkg::sat24(64'(dx));
        rz_r   <= tjs_pkg::sat24(64'(dz));
        dy_r   <= dyv;
        trig_r <= in_trigger_level;
        dir_r  <= in_select_pressed ? tjs_pkg::DIR_MINUS :
                  (in_start_pressed ? tjs_pkg::DIR_PLUS : tjs_pkg::DIR_NONE);
      end
      tjs_pkg::OP_SQX:    ry_r <= tjs_pkg::sat24(prod_r);
      tjs_pkg::OP_SQZ:    h2_r <= prod_r[47:0];
      tjs_pkg::OP_SQY:    h2_r <= h2_r + prod_r[47:0];
      tjs_pkg::OP_CCLAMP: c_r  <= c_cl;
      tjs_pkg::OP_HCLAMP: h_r  <= h_cl;
      tjs_pkg::OP_BB:     aa_r <= prod_r[19:0];
      tjs_pkg::OP_CC:     bb_r <= prod_r[19:0];
      tjs_pkg::OP_BC:     cc_r <= prod_r[37:0];
      tjs_pkg::OP_AB:     bc_r <= prod_r[28:0];
      tjs_pkg::OP_ABW:    ab_r <= prod_r[19:0];
      tjs_pkg::OP_ACLOAD: begin
        du_r  <= d_sel;
        mu_r  <= m_sel;
        neg_r <= n_sel[40];
      end
      tjs_pkg::OP_NORM: begin
        du_r <= du_r >> 1;
        mu_r <= mu_r >> 1;
      end
      tjs_pkg::OP_MM:     t_r <= prod_r[59:0];
      tjs_pkg::OP_ACSTORE: begin
        if (cmd.gamma) gamma_r <= co_ang;
        else alpha_r <= co_ang;
      end
      tjs_pkg::OP_OUT: begin
        out_joint_one_angle   <= j1r[tjs_pkg::ANG_W-1:0];
        out_joint_two_angle   <= j2r[tjs_pkg::ANG_W-1:0];
        out_rel_x             <= rx_r;
        out_rel_y             <= ry_r;
        out_rel_z             <= rz_r;
        out_arm_enabled       <= enable_r;
        out_trigger_out       <= trig_r;
        out_direction_command <= dir_r;
      end
      default: ;
    endcase
  end

  tjs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .root     (sq_root),
    .done     (sq_done)
  );

  tjs_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (co_start),
    .y_in  (co_y),
    .x_in  (co_x),
    .angle (co_ang),
    .done  (co_done)
  );

endmodule

// ===== test/two_link_arm_joint_solver_core_tb.sv =====
// Self-checking testbench for two_link_arm_joint_solver_core. It predicts every result word
// and checks the output stream against it. Depends on tjs_pkg and the core RTL only.
module two_link_arm_joint_solver_core_tb;

  localparam int ITERS = 16;
  // Indexes past the six registers; the core must ignore writes to them.
  localparam logic [tjs_pkg::CFGI_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [tjs_pkg::CFGI_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 400;   // longer than one word's worth of work
  localparam int HOLD_CYCLES  = 3000;  // long receiver hold-off

  localparam longint ATAN_DEG[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0};

  typedef struct {
    logic [23:0] x, y, z;
    logic        mv, sel, st;
    logic [7:0]  trig;
  } sample_t;

  typedef struct {
    logic [17:0] j1, j2;
    logic [23:0] rx, ry, rz;
    logic        en;
    logic [7:0]  trig;
    logic [1:0]  dir;
  } joint_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [tjs_pkg::POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_move_pressed = 1'b0, in_select_pressed = 1'b0, in_start_pressed = 1'b0;
  logic [7:0] in_trigger_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tjs_pkg::ANG_W-1:0] out_joint_one_angle, out_joint_two_angle;
  logic signed [tjs_pkg::POS_W-1:0] out_rel_x, out_rel_y, out_rel_z;
  logic out_arm_enabled;
  logic [7:0] out_trigger_out;
  logic [1:0] out_direction_command;
  logic cfg_we = 1'b0;
  logic [tjs_pkg::CFGI_W-1:0] cfg_index = '0;
  logic [tjs_pkg::CFG_W-1:0] cfg_wdata = '0;

  two_link_arm_joint_solver_core #(.CORDIC_ITERATIONS(ITERS)) u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor state
  longint unsigned arm_upper = 215, arm_lower = 160, reach_lo = 100, reach_hi = 350;
  longint unsigned reach_scale = 10, y_gain = 3;
  bit     arm_on = 0, move_prev = 0;
  longint ctr_x = 0, ctr_y = 0, ctr_z = 0;

  sample_t     pending[$];      // words waiting to be offered
  joint_word_t joint_expect[$]; // predicted result words, oldest first
  int  fail_count = 0;
  bit  gaps_on = 1'b1;          // random idling on both sides
  bit  hold_in = 1'b0;          // sender pause request
  bit  hold_start = 1'b0;
  int  hold_cnt = 0;
  bit  last_mv = 1'b0;          // move state of the last generated word
  logic [23:0] gen_cx = '0, gen_cy = '0, gen_cz = '0;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // vectoring CORDIC, degrees Q.16; left half-plane pre-rotated by 90
  function automatic longint cordic_deg(longint y, longint x);
    longint acc = 0;
    longint t, dx, dy;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; acc = -90 * 65536;
      end
    end
    for (int i = 0; i < ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += ATAN_DEG[i];
      end else begin
        x -= dx; y += dy; acc -= ATAN_DEG[i];
      end
    end
    return acc;
  endfunction

  // arccos(n/d), cosine saturated to +-1, operands narrowed below 2^30
  function automatic longint arccos_deg(longint n, longint d);
    bit neg = n < 0;
    longint m = neg ? -n : n;
    longint unsigned du, mu, s;
    if (m > d) m = d;
    du = d;
    mu = m;
    while (du >= (64'd1 << 30)) begin
      du >>= 1;
      mu >>= 1;
    end
    s = isqrt64(du * du - mu * mu);
    return cordic_deg(longint'(s), neg ? -longint'(mu) : longint'(mu));
  endfunction

  function automatic logic [17:0] round_q8(longint v);
    longint r = (v + 128) >>> 8;
    return r[17:0];
  endfunction

  task automatic predict_joints(input sample_t s);
    longint x, y, z, rx, ry, rz, c, h, lo, hi, a, b, alpha, gam, elev;
    longint unsigned sq;
    joint_word_t w;
    x = longint'(signed'(s.x));
    y = longint'(signed'(s.y));
    z = longint'(signed'(s.z));
    if (s.mv && !move_prev) begin
      arm_on = !arm_on;
      ctr_x = x; ctr_y = y; ctr_z = z;
    end
    move_prev = s.mv;
    rx = clip24(x - ctr_x);
    ry = clip24((y - ctr_y) * longint'(y_gain));
    rz = clip24(ctr_z - z);
    sq = rx * rx + ry * ry + rz * rz;
    c = longint'(isqrt64(sq)) * longint'(reach_scale);
    lo = longint'(reach_lo) * 256;
    hi = longint'(reach_hi) * 256;
    if (!(lo <= c && c <= hi)) c = (c < lo) ? lo : hi;
    h = longint'(isqrt64(rx * rx + rz * rz));
    if (h < 2560) h = 2560;
    if (h > 256000) h = 256000;
    a = arm_upper;
    b = arm_lower;
    alpha = arccos_deg((b * b - a * a) * 65536 + c * c, 2 * b * c * 256);
    gam = arccos_deg((a * a + b * b) * 65536 - c * c, 2 * a * b * 65536);
    elev = cordic_deg(h, ry);
    w.j1 = round_q8(270 * 65536 - alpha - elev);
    w.j2 = round_q8(270 * 65536 - alpha - gam - elev);
    w.rx = rx[23:0];
    w.ry = ry[23:0];
    w.rz = rz[23:0];
    w.en = arm_on;
    w.trig = s.trig;
    w.dir = s.sel ? tjs_pkg::DIR_MINUS : (s.st ? tjs_pkg::DIR_PLUS : tjs_pkg::DIR_NONE);
    joint_expect.push_back(w);
  endtask

  // ---------------------------------------------------------------- sender
  int in_gap = 0;
  always @(posedge clk) begin
    sample_t s;
    bit v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      v = in_valid;
      if (in_valid && !in_stall) begin
        s.x = in_pos_x; s.y = in_pos_y; s.z = in_pos_z;
        s.mv = in_move_pressed; s.sel = in_select_pressed; s.st = in_start_pressed;
        s.trig = in_trigger_level;
        predict_joints(s);
        v = 1'b0;
        in_gap = gaps_on ? $urandom_range(0, 13) : 0;
      end
      if (!v) begin
        if (in_gap > 0) in_gap--;
        else if (pending.size() > 0 && !hold_in) begin
          s = pending.pop_front();
          in_pos_x <= s.x; in_pos_y <= s.y; in_pos_z <= s.z;
          in_move_pressed <= s.mv; in_select_pressed <= s.sel;
          in_start_pressed <= s.st; in_trigger_level <= s.trig;
          v = 1'b1;
        end
      end
      in_valid <= v;
    end
  end

  // ---------------------------------------------------------------- long hold-off counter
  always @(posedge clk) begin
    if (hold_start) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // ---------------------------------------------------------------- receiver and checker
  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fail_count++;
    end
  endtask

  int out_gap = 0;
  always @(posedge clk) begin
    joint_word_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (joint_expect.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          w = joint_expect.pop_front();
          check_field("joint_one_angle", w.j1, out_joint_one_angle[17:0]);
          check_field("joint_two_angle", w.j2, out_joint_two_angle[17:0]);
          check_field("rel_x", w.rx, out_rel_x[23:0]);
          check_field("rel_y", w.ry, out_rel_y[23:0]);
          check_field("rel_z", w.rz, out_rel_z[23:0]);
          check_field("arm_enabled", w.en, out_arm_enabled);
          check_field("trigger_out", w.trig, out_trigger_out);
          check_field("direction_command", w.dir, out_direction_command);
        end
        out_gap = gaps_on ? $urandom_range(0, 13) : 0;
      end else if (out_gap > 0) out_gap--;
      out_stall <= (out_gap > 0) || (hold_cnt > 0);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic put(input logic [23:0] x, y, z, input bit mv, sel, st,
                     input logic [7:0] trig);
    sample_t s;
    s.x = x; s.y = y; s.z = z; s.mv = mv; s.sel = sel; s.st = st; s.trig = trig;
    pending.push_back(s);
    if (mv && !last_mv) begin
      gen_cx = x; gen_cy = y; gen_cz = z;
    end
    last_mv = mv;
  endtask

  // mostly small moves around the current centre so reach lands in the clamp window
  task automatic put_random();
    logic [23:0] x, y, z;
    bit mv;
    int pick;
    pick = $urandom_range(0, 9);
    mv = ($urandom_range(0, 7) == 0) ? !last_mv : last_mv;
    if (pick < 2) begin
      x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
    end else begin
      x = gen_cx + 24'($signed($urandom_range(0, 40000)) - 20000);
      y = gen_cy + 24'($signed($urandom_range(0, 8000)) - 4000);
      z = gen_cz + 24'($signed($urandom_range(0, 40000)) - 20000);
    end
    put(x, y, z, mv, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || joint_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write; the predictor copy follows the same masking as the core
  task automatic write_reg(input logic [tjs_pkg::CFGI_W-1:0] idx,
                           input logic [tjs_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tjs_pkg::CFG_UPPER: arm_upper = val[9:0];
      tjs_pkg::CFG_LOWER: arm_lower = val[9:0];
      tjs_pkg::CFG_RMIN:  reach_lo = val;
      tjs_pkg::CFG_RMAX:  reach_hi = val;
      tjs_pkg::CFG_SCALE: reach_scale = val[5:0];
      tjs_pkg::CFG_GAIN:  y_gain = val[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [10:0] up, lw, rmin, rmax, sc, gn);
    write_reg(tjs_pkg::CFG_UPPER, up);
    write_reg(tjs_pkg::CFG_LOWER, lw);
    write_reg(tjs_pkg::CFG_RMIN, rmin);
    write_reg(tjs_pkg::CFG_RMAX, rmax);
    write_reg(tjs_pkg::CFG_SCALE, sc);
    write_reg(tjs_pkg::CFG_GAIN, gn);
  endtask

  task automatic run_random(input int n);
    repeat (n) put_random();
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: buttons, trigger extremes, centre capture and saturation
    put(24'h000000, 24'h000000, 24'h000000, 0, 0, 0, 8'h00);
    put(24'h000A00, 24'h000300, 24'hFFF600, 0, 1, 0, 8'hFF);
    put(24'h000A00, 24'h000300, 24'hFFF600, 0, 0, 1, 8'h5A);
    put(24'h000A00, 24'h000300, 24'hFFF600, 0, 1, 1, 8'hA5);
    put(24'h800000, 24'h800000, 24'h800000, 1, 0, 0, 8'h01);  // enable, centre at minimum
    put(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 0, 0, 8'h80);  // held: saturates
    put(24'h800000, 24'h800000, 24'h800000, 0, 0, 0, 8'h7F);  // zero offset
    put(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 0, 0, 8'hFE);  // disable, centre at maximum
    put(24'h800000, 24'h800000, 24'h800000, 1, 0, 0, 8'h02);
    put(24'h000000, 24'h000000, 24'h000000, 0, 0, 0, 8'h03);
    put(24'h000000, 24'h000000, 24'h000000, 1, 0, 0, 8'h04);  // re-centre at origin
    put(24'h7FFFFF, 24'h000000, 24'h800000, 1, 0, 0, 8'h05);  // reach clamps high
    put(24'h000100, 24'h000000, 24'h000000, 1, 0, 0, 8'h06);  // reach clamps low
    put(24'h000000, 24'h7FFFFF, 24'h000000, 1, 0, 0, 8'h07);  // straight up
    put(24'h000000, 24'h800000, 24'h000000, 1, 0, 0, 8'h08);  // straight down
    put(24'h002000, 24'hFFF000, 24'h001000, 1, 1, 0, 8'h09);
    wait_idle();

    // degenerate triangle: zero link and zero reach; spare indexes ignored
    set_all(11'd0, 11'd1023, 11'd0, 11'd0, 11'd0, 11'd0);
    write_reg(CFG_SPARE_LO, 11'h7FF);
    write_reg(CFG_SPARE_HI, 11'h555);
    put(24'h001000, 24'h002000, 24'h003000, 0, 0, 0, 8'h10);
    put(24'hFF0000, 24'h010000, 24'h000000, 0, 1, 0, 8'h11);
    run_random(20);

    // default-like setting, long receiver hold-off while the sender keeps going
    set_all(11'd215, 11'd160, 11'd100, 11'd350, 11'd10, 11'd3);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    run_random(120);

    // sender pause: words queue up while nothing is offered, then go out with no gaps
    gaps_on = 1'b0;
    hold_in = 1'b1;
    repeat (40) put_random();
    repeat (50) @(posedge clk);
    hold_in = 1'b0;
    wait_idle();
    run_random(60);
    gaps_on = 1'b1;

    // all registers at their maximum
    set_all(11'd1023, 11'd1023, 11'd2047, 11'd2047, 11'd63, 11'd15);
    run_random(80);

    // crossed reach bounds, impossible triangles
    set_all(11'd1, 11'd500, 11'd900, 11'd50, 11'd1, 11'd1);
    run_random(70);

    // random settings
    repeat (3) begin
      set_all(11'($urandom_range(1, 1023)), 11'($urandom_range(1, 1023)),
              11'($urandom_range(0, 400)), 11'($urandom_range(100, 2047)),
              11'($urandom_range(1, 63)), 11'($urandom_range(1, 15)));
      run_random(50);
    end

    if (fail_count == 0) $display("two_link_arm_joint_solver_core_tb: PASS");
    else $display("two_link_arm_joint_solver_core_tb: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("two_link_arm_joint_solver_core_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tjs_pkg.sv
hdl/tjs_sqrt.sv
hdl/tjs_cordic.sv
hdl/tjs_ctrl.sv
hdl/tjs_dp.sv
hdl/two_link_arm_joint_solver_core.sv
test/two_link_arm_joint_solver_core_tb.sv
